FILE: hdl/pbgra_pkg.sv
// Shared types and constants for the premultiplied BGRA pixel converter.
package pbgra_pkg;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [1:0] FMT_RGB  = 2'd0;
	localparam logic [1:0] FMT_RGBA = 2'd1;
	localparam logic [1:0] FMT_GA   = 2'd2;
	localparam logic [1:0] FMT_GRAY = 2'd3;

	localparam logic REG_PIXEL_FORMAT = 1'b0;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       last;
	} pix_t;

	typedef struct packed {
		logic accept;
		logic s2_load;
	} flow_t;

endpackage

FILE: hdl/pbgra_cfg.sv
// APB register block holding the source pixel format.
module pbgra_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbgra_pkg::PADDR_W-1:0] paddr,
	input  logic [pbgra_pkg::PDATA_W-1:0] pwdata,
	output logic [pbgra_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output logic [1:0]                    fmt
);
	import pbgra_pkg::*;

	logic [1:0] fmt_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_PIXEL_FORMAT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB;
		end else if (wr_en) begin
			fmt_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PIXEL_FORMAT) begin
			prdata = {{(PDATA_W-2){1'b0}}, fmt_q};
		end
	end

	assign fmt = fmt_q;

endmodule

FILE: hdl/pbgra_gather.sv
// Byte gathering and pixel assembly into the first pipeline register.
module pbgra_gather (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          fmt,
	input  pbgra_pkg::flow_t    flow,
	input  logic [7:0]          src_byte,
	input  logic                last_byte,
	output pbgra_pkg::pix_t     pix_s1,
	output logic                valid_s1
);
	import pbgra_pkg::*;

	logic [1:0] pos_q;
	logic [7:0] held_q [3];
	logic [2:0] bpp;
	logic       complete;
	pix_t       pix;

	always_comb begin
		case (fmt)
			FMT_RGB:  bpp = 3'd3;
			FMT_RGBA: bpp = 3'd4;
			FMT_GA:   bpp = 3'd2;
			FMT_GRAY: bpp = 3'd1;
			default:  bpp = 3'd1;
		endcase
	end

	assign complete = ({1'b0, pos_q} + 3'd1) >= bpp;

	always_comb begin
		pix.last = last_byte;
		case (fmt)
			FMT_RGB: begin
				pix.red   = held_q[0];
				pix.green = held_q[1];
				pix.blue  = src_byte;
				pix.alpha = ALPHA_OPAQUE;
			end
			FMT_RGBA: begin
				pix.red   = held_q[0];
				pix.green = held_q[1];
				pix.blue  = held_q[2];
				pix.alpha = src_byte;
			end
			FMT_GA: begin
				pix.red   = held_q[0];
				pix.green = held_q[0];
				pix.blue  = held_q[0];
				pix.alpha = src_byte;
			end
			default: begin
				pix.red   = src_byte;
				pix.green = src_byte;
				pix.blue  = src_byte;
				pix.alpha = ALPHA_OPAQUE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 2'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (flow.accept) begin
				if (complete || last_byte) begin
					pos_q <= 2'd0;
				end else begin
					pos_q <= pos_q + 2'd1;
				end
			end
			if (flow.accept && complete) begin
				valid_s1 <= 1'b1;
			end else if (flow.s2_load) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (flow.accept && !complete && !last_byte) begin
			case (pos_q)
				2'd0:    held_q[0] <= src_byte;
				2'd1:    held_q[1] <= src_byte;
				2'd2:    held_q[2] <= src_byte;
				default: held_q[2] <= held_q[2];
			endcase
		end
		if (flow.accept && complete) begin
			pix_s1 <= pix;
		end
	end

endmodule

FILE: hdl/pbgra_premul.sv
// Alpha premultiply of the three colour channels into the result register.
module pbgra_premul (
	input  logic            clk,
	input  logic            arst_n,
	input  pbgra_pkg::flow_t flow,
	input  pbgra_pkg::pix_t pix_s1,
	input  logic            pix_stall,
	output logic            pix_valid,
	output pbgra_pkg::pix_t pix_s2
);
	import pbgra_pkg::*;

	function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
		logic [15:0] x;
		logic [15:0] y;
		x = ({8'd0, c} * {8'd0, a}) + 16'd127;
		y = x + 16'd1 + {8'd0, x[15:8]};
		return y[15:8];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else if (flow.s2_load) begin
			pix_valid <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.s2_load) begin
			pix_s2.red   <= premul(pix_s1.red, pix_s1.alpha);
			pix_s2.green <= premul(pix_s1.green, pix_s1.alpha);
			pix_s2.blue  <= premul(pix_s1.blue, pix_s1.alpha);
			pix_s2.alpha <= pix_s1.alpha;
			pix_s2.last  <= pix_s1.last;
		end
	end

endmodule

FILE: hdl/pixel_to_premultiplied_bgra_unit.sv
// Top level of the premultiplied BGRA pixel converter.
//
//   channel   | handshake              | payload
//   ----------+------------------------+----------------------------------------
//   source    | src_valid / src_stall  | src_byte, last_byte
//   result    | pix_valid / pix_stall  | out_blue, out_green, out_red, out_alpha,
//             |                        | last_pixel
//   config    | APB, pready always 1   | pixel_format at address 0
//
// One byte is taken every cycle unless src_stall is high. A completed pixel is
// registered first for assembly, then for the premultiply multipliers.
// Reset clears the byte position, the format (RGB) and both valid flags.
// A stall on the result side holds the result register and stalls the source side
// only when the assembly register is full and cannot advance.
module pixel_to_premultiplied_bgra_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pbgra_pkg::PADDR_W-1:0] paddr,
	input  logic [pbgra_pkg::PDATA_W-1:0] pwdata,
	output logic [pbgra_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	input  logic                          src_valid,
	output logic                          src_stall,
	input  logic [7:0]                    src_byte,
	input  logic                          last_byte,
	output logic                          pix_valid,
	input  logic                          pix_stall,
	output logic [7:0]                    out_blue,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_alpha,
	output logic                          last_pixel
);
	import pbgra_pkg::*;

	logic [1:0] fmt;
	flow_t      flow;
	pix_t       pix_s1;
	pix_t       pix_s2;
	logic       valid_s1;

	assign flow.s2_load = valid_s1 && (!pix_valid || !pix_stall);
	assign src_stall    = valid_s1 && !flow.s2_load;
	assign flow.accept  = src_valid && !src_stall;

	pbgra_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fmt     (fmt)
	);

	pbgra_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.fmt       (fmt),
		.flow      (flow),
		.src_byte  (src_byte),
		.last_byte (last_byte),
		.pix_s1    (pix_s1),
		.valid_s1  (valid_s1)
	);

	pbgra_premul u_premul (
		.clk       (clk),
		.arst_n    (arst_n),
		.flow      (flow),
		.pix_s1    (pix_s1),
		.pix_stall (pix_stall),
		.pix_valid (pix_valid),
		.pix_s2    (pix_s2)
	);

	assign out_blue   = pix_s2.blue;
	assign out_green  = pix_s2.green;
	assign out_red    = pix_s2.red;
	assign out_alpha  = pix_s2.alpha;
	assign last_pixel = pix_s2.last;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (valid_s1 && pix_valid && pix_stall))
		else $error("source stalled without a full pipeline");

	a_gray_completes: assert property (@(posedge clk) disable iff (!arst_n)
		(flow.accept && fmt == FMT_GRAY) |=> valid_s1)
		else $error("gray byte did not complete a pixel");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		flow.s2_load |=> pix_valid)
		else $error("result register loaded without valid");

endmodule
